FILE: rtl/core/fda_pkg.sv
`default_nettype none

package fda_pkg;

  localparam int MagW      = 32;
  localparam int AccW      = 48;
  localparam int WholeW    = 32;
  localparam int NumDigits = 10;
  localparam int BcdW      = 4 * NumDigits;
  localparam int PlacesW   = 4;
  localparam int BitCntW   = $clog2(WholeW);

  localparam logic [AccW:0] HalfLsb = (AccW + 1)'(32768);

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPoint = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;

  typedef struct packed {
    logic               neg;
    logic [PlacesW-1:0] places;
  } fda_meta_t;

endpackage

`default_nettype wire

FILE: rtl/core/fixed_decimal_to_ascii.sv
// fixed_decimal_to_ascii: prints a signed Q15.16 value as ASCII decimal text
// input channel: in_value (Q15.16) and in_decimal_places, taken when in_valid
//   is high and in_stall is low; places above MAX_DECIMALS are clamped
// output channel: one character per transaction on out_character, with
//   out_last high on the final character of a value; a transaction completes
//   when out_valid is high and out_stall is low
// text: optional '-', integer digits without leading zeros (one zero below
//   one), '.' and fraction digits if places > 0; halves round up, saturating
// sequence: scaling (one times-ten step per place plus rounding), a 32-step
//   bit-serial binary to bcd conversion, a handoff to the emitter, then one
//   character per cycle while out_stall is low (at most 12 characters)
// overlap: the three units overlap, so a new value is taken while earlier
//   ones are in flight; the 32-step bcd conversion shift loop sets the pace
// reset: synchronous; rst_n low empties all units and the output register
// stall: a stalled character holds; the units behind it fill and then hold
//   their results, and in_stall rises once the scaler is occupied
`default_nettype none

module fixed_decimal_to_ascii
  import fda_pkg::*;
#(
  parameter int MAX_DECIMALS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_value,
  input  wire logic [2:0]  in_decimal_places,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_character,
  output logic             out_last
);

  localparam logic [PlacesW-1:0] MaxPlaces = PlacesW'(MAX_DECIMALS);

  fda_meta_t          in_meta;
  logic [PlacesW-1:0] req_places;

  logic               sc_ready;
  logic               sc_valid;
  logic [WholeW-1:0]  sc_whole;
  fda_meta_t          sc_meta;
  logic               bc_ready;
  logic               bc_valid;
  logic [BcdW-1:0]    bc_bcd;
  fda_meta_t          bc_meta;
  logic               em_ready;

  assign req_places     = {1'b0, in_decimal_places};
  assign in_meta.neg    = in_value[31];
  assign in_meta.places = (req_places > MaxPlaces) ? MaxPlaces : req_places;
  assign in_stall       = !sc_ready;

  fda_scaler u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (sc_ready),
    .req_value (in_value),
    .req_meta  (in_meta),
    .rsp_valid (sc_valid),
    .rsp_ready (bc_ready),
    .rsp_whole (sc_whole),
    .rsp_meta  (sc_meta)
  );

  fda_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (sc_valid),
    .req_ready (bc_ready),
    .req_whole (sc_whole),
    .req_meta  (sc_meta),
    .rsp_valid (bc_valid),
    .rsp_ready (em_ready),
    .rsp_bcd   (bc_bcd),
    .rsp_meta  (bc_meta)
  );

  fda_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (bc_valid),
    .req_ready     (em_ready),
    .req_bcd       (bc_bcd),
    .req_meta      (bc_meta),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

FILE: rtl/core/fda_scaler.sv
`default_nettype none

module fda_scaler
  import fda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic [MagW-1:0]   req_value,
  input  wire fda_meta_t         req_meta,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic [WholeW-1:0]      rsp_whole,
  output fda_meta_t              rsp_meta
);

  typedef enum logic [3:0] {
    SC_IDLE = 4'b0001,
    SC_MUL  = 4'b0010,
    SC_RND  = 4'b0100,
    SC_DONE = 4'b1000
  } fda_sc_state_t;

  fda_sc_state_t      state_r, state_nxt;
  logic [AccW-1:0]    acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic [PlacesW-1:0] cnt_r, cnt_nxt;
  fda_meta_t          meta_r, meta_nxt;
  logic [WholeW-1:0]  whole_r, whole_nxt;

  logic [AccW+3:0]    prod;
  logic [AccW:0]      rnd;
  logic [MagW-1:0]    mag;
  logic               ovf_any;

  // times ten as x*8 + x*2, overflow past the accumulator is sticky
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign rnd  = {1'b0, acc_r} + HalfLsb;
  assign mag  = req_value[MagW-1] ? (~req_value + MagW'(1)) : req_value;
  assign ovf_any = ovf_r | rnd[AccW];

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    meta_nxt  = meta_r;
    whole_nxt = whole_r;
    unique case (state_r)
      SC_IDLE: begin
        if (req_valid) begin
          acc_nxt   = {{(AccW-MagW){1'b0}}, mag};
          ovf_nxt   = 1'b0;
          cnt_nxt   = req_meta.places;
          meta_nxt  = req_meta;
          state_nxt = SC_MUL;
        end
      end
      SC_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = SC_RND;
        end else begin
          acc_nxt = prod[AccW-1:0];
          ovf_nxt = ovf_r | (|prod[AccW+3:AccW]);
          cnt_nxt = cnt_r - PlacesW'(1);
        end
      end
      SC_RND: begin
        whole_nxt = ovf_any ? {WholeW{1'b1}} : rnd[AccW-1:AccW-WholeW];
        state_nxt = SC_DONE;
      end
      SC_DONE: begin
        if (rsp_ready) begin
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    ovf_r   <= ovf_nxt;
    cnt_r   <= cnt_nxt;
    meta_r  <= meta_nxt;
    whole_r <= whole_nxt;
  end

  assign req_ready = (state_r == SC_IDLE);
  assign rsp_valid = (state_r == SC_DONE);
  assign rsp_whole = whole_r;
  assign rsp_meta  = meta_r;

endmodule

`default_nettype wire

FILE: rtl/core/fda_bcd.sv
`default_nettype none

module fda_bcd
  import fda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic [WholeW-1:0] req_whole,
  input  wire fda_meta_t         req_meta,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic [BcdW-1:0]        rsp_bcd,
  output fda_meta_t              rsp_meta
);

  typedef enum logic [2:0] {
    BC_IDLE  = 3'b001,
    BC_SHIFT = 3'b010,
    BC_DONE  = 3'b100
  } fda_bc_state_t;

  fda_bc_state_t      state_r, state_nxt;
  logic [WholeW-1:0]  bin_r, bin_nxt;
  logic [BcdW-1:0]    bcd_r, bcd_nxt;
  logic [BitCntW-1:0] cnt_r, cnt_nxt;
  fda_meta_t          meta_r, meta_nxt;

  logic [BcdW-1:0]    adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3) : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    meta_nxt  = meta_r;
    unique case (state_r)
      BC_IDLE: begin
        if (req_valid) begin
          bin_nxt   = req_whole;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          meta_nxt  = req_meta;
          state_nxt = BC_SHIFT;
        end
      end
      BC_SHIFT: begin
        bcd_nxt = {adj[BcdW-2:0], bin_r[WholeW-1]};
        bin_nxt = {bin_r[WholeW-2:0], 1'b0};
        cnt_nxt = cnt_r + BitCntW'(1);
        if (cnt_r == {BitCntW{1'b1}}) begin
          state_nxt = BC_DONE;
        end
      end
      BC_DONE: begin
        if (rsp_ready) begin
          state_nxt = BC_IDLE;
        end
      end
      default: begin
        state_nxt = BC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    meta_r <= meta_nxt;
  end

  assign req_ready = (state_r == BC_IDLE);
  assign rsp_valid = (state_r == BC_DONE);
  assign rsp_bcd   = bcd_r;
  assign rsp_meta  = meta_r;

endmodule

`default_nettype wire

FILE: rtl/core/fda_emit.sv
`default_nettype none

module fda_emit
  import fda_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire logic [BcdW-1:0] req_bcd,
  input  wire fda_meta_t       req_meta,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_character,
  output logic                 out_last
);

  typedef enum logic [3:0] {
    EM_IDLE  = 4'b0001,
    EM_SIGN  = 4'b0010,
    EM_DIGIT = 4'b0100,
    EM_POINT = 4'b1000
  } fda_em_state_t;

  fda_em_state_t      state_r, state_nxt;
  logic [BcdW-1:0]    bcd_r, bcd_nxt;
  logic [PlacesW-1:0] pos_r, pos_nxt;
  logic [PlacesW-1:0] places_r, places_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [PlacesW-1:0] lead;
  logic [PlacesW-1:0] start;
  logic [3:0]         digit;
  logic               can_emit;

  // highest nonzero digit, at least the ones digit and the padded places
  always_comb begin
    lead = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (req_bcd[4*i +: 4] != 4'd0) begin
        lead = PlacesW'(i);
      end
    end
    start = (lead > req_meta.places) ? lead : req_meta.places;
  end

  assign digit    = bcd_r[4*pos_r +: 4];
  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    bcd_nxt       = bcd_r;
    pos_nxt       = pos_r;
    places_nxt    = places_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      EM_IDLE: begin
        if (req_valid) begin
          bcd_nxt    = req_bcd;
          pos_nxt    = start;
          places_nxt = req_meta.places;
          state_nxt  = req_meta.neg ? EM_SIGN : EM_DIGIT;
        end
      end
      EM_SIGN: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CharMinus;
          out_last_nxt  = 1'b0;
          state_nxt     = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CharZero + {4'd0, digit};
          out_last_nxt  = (pos_r == '0);
          if (pos_r == '0) begin
            state_nxt = EM_IDLE;
          end else begin
            pos_nxt   = pos_r - PlacesW'(1);
            state_nxt = (pos_r == places_r) ? EM_POINT : EM_DIGIT;
          end
        end
      end
      EM_POINT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CharPoint;
          out_last_nxt  = 1'b0;
          state_nxt     = EM_DIGIT;
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r      <= bcd_nxt;
    pos_r      <= pos_nxt;
    places_r   <= places_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign req_ready     = (state_r == EM_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_char_r >= CharZero && out_char_r <= CharZero + 8'd9)
    else $error("final character of a value is not a digit");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EM_DIGIT |-> pos_r < PlacesW'(NumDigits))
    else $error("digit position beyond the bcd register");

  a_point_place: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EM_POINT |-> places_r != '0 && pos_r == places_r - PlacesW'(1))
    else $error("decimal point at the wrong digit position");

  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EM_SIGN |-> $past(state_r) == EM_IDLE || $past(state_r) == EM_SIGN)
    else $error("sign emitted after digits of the same value");
`endif

endmodule

`default_nettype wire

FILE: test/fixed_decimal_to_ascii_checker.sv
module fixed_decimal_to_ascii_checker
  import fda_pkg::*;
#(
  parameter int MAX_DECIMALS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_value,
  input  logic [2:0]  in_decimal_places,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_character,
  input  logic        out_last,
  output int          fail_count,
  output int          chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } glyph_t;

  glyph_t char_q[$];
  int     mismatches = 0;
  int     queued = 0;
  int     chars_seen = 0;

  assign fail_count    = mismatches;
  assign chars_pending = queued;

  task automatic report_mismatch(input string what);
    $display("%0.3f ns: character %0d: %s", $realtime, chars_seen, what);
    mismatches++;
  endtask

  // sign, rounded scaled magnitude, then digits with zero padding and point
  function automatic void render_decimal(input logic [31:0] value,
                                         input logic [2:0]  places_in);
    logic [31:0] abs_value;
    logic [63:0] scaled;
    logic [31:0] whole;
    logic [3:0]  digits[12];
    logic [7:0]  text[$];
    int          places;
    int          nd;
    places = (places_in > MAX_DECIMALS) ? MAX_DECIMALS : int'(places_in);
    nd = 0;
    if (value[31]) begin
      text.push_back(CharMinus);
      abs_value = ~value + 32'd1;
    end else begin
      abs_value = value;
    end
    scaled = {32'd0, abs_value};
    repeat (places) scaled = scaled * 64'd10;
    scaled = (scaled + 64'd32768) >> 16;
    whole = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    while (whole != 0) begin
      digits[nd] = 4'(whole % 10);
      whole = whole / 10;
      nd++;
    end
    while (nd < places) begin
      digits[nd] = 4'd0;
      nd++;
    end
    if (nd == places) begin
      digits[nd] = 4'd0;
      nd++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      if (i + 1 == places) text.push_back(CharPoint);
      text.push_back(CharZero + 8'(digits[i]));
    end
    foreach (text[i]) begin
      char_q.push_back('{character: text[i], last: (i == text.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (!rst_n) begin
      char_q.delete();
    end else begin
      if (in_valid && !in_stall) render_decimal(in_value, in_decimal_places);
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character 8'h%02h", out_character));
        end else begin
          want = char_q.pop_front();
          if (out_character !== want.character) begin
            report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h",
                                      out_character, want.character));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
          end
        end
        chars_seen++;
      end
    end
    queued <= char_q.size();
  end

endmodule

FILE: test/fixed_decimal_to_ascii_tb.sv
module fixed_decimal_to_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDecimals = 6;
  localparam int IdleLimit   = 4000;
  localparam int PhaseItems  = 42;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_value = '0;
  logic [2:0]  in_decimal_places = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_character;
  logic        out_last;

  int fail_count;
  int chars_pending;
  int send_gap_pct = 9;
  int stall_pct = 88;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  fixed_decimal_to_ascii #(.MAX_DECIMALS(MaxDecimals)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_decimal_places(in_decimal_places),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_character    (out_character),
    .out_last         (out_last)
  );

  fixed_decimal_to_ascii_checker #(.MAX_DECIMALS(MaxDecimals)) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_decimal_places(in_decimal_places),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_character    (out_character),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .chars_pending    (chars_pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_value(input logic [31:0] value, input logic [2:0] places);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_value          <= value;
    in_decimal_places <= places;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(3))
      0:       v = $urandom;
      1:       v = $urandom_range(32'h000F_FFFF);
      2:       v = 32'($urandom_range(2047)) << 15;
      default: v = 32'h7FFF_FFFF - 32'($urandom_range(65535));
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_value(random_value(), 3'($urandom_range(7)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_value(32'h0000_0000, 3'd0);
    send_value(32'h0000_0000, 3'd6);
    send_value(32'h7FFF_FFFF, 3'd0);
    send_value(32'h7FFF_FFFF, 3'd4);
    send_value(32'h7FFF_FFFF, 3'd6);
    send_value(32'h8000_0000, 3'd0);
    send_value(32'h8000_0000, 3'd3);
    send_value(32'h8000_0000, 3'd6);
    send_value(32'hFFFF_FFFF, 3'd0);
    send_value(32'hFFFF_FFFF, 3'd2);
    send_value(32'h0001_8000, 3'd7);
    send_value(32'hFFFE_8000, 3'd7);
    send_value(32'h0000_8000, 3'd0);
    send_value(32'hFFFF_8000, 3'd0);
    send_value(32'h0001_8000, 3'd0);
    send_value(32'h0000_4000, 3'd1);
    send_value(32'h0000_4000, 3'd2);
    send_value(32'h0001_0000, 3'd1);
    send_value(32'h1234_5678, 3'd4);
    send_value(32'h0000_0100, 3'd3);
    send_value(32'h0000_0042, 3'd6);
    send_value(32'hFF84_8B44, 3'd5);
    send_value(32'h0009_FFFF, 3'd5);
    send_random(PhaseItems);
    drain_text();

    send_gap_pct = 88;
    stall_pct    = 9;
    send_random(PhaseItems);
    drain_text();

    send_gap_pct = 0;
    stall_pct    = 0;
    send_random(PhaseItems);
    drain_text();

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
